// File: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl in this folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define MIPB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mipb assertion failed");

// clocked property that also holds across reset
`define MIPB_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mipb assertion failed");

`endif

// File: rtl/core/mipb_pkg.sv
// ----------------------------------------------------------------------------
// mipb_pkg
// Shared sizes, operation codes and status codes of the MAC/IPv4 binding table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mipb_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int MAC_W   = 48;
  localparam int IP_W    = 32;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DELETE   = 2'd1,
    OP_SEARCH   = 2'd2,
    OP_CONFLICT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EXISTS   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

endpackage

// File: rtl/core/mac_ip_binding_table_core.sv
// ----------------------------------------------------------------------------
// mac_ip_binding_table_core
// Table of unique MAC-to-IPv4 bindings with add, delete, search and conflict check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request beat: op, mac, ip.
//   Output channel (out_valid / out_stall) returns one result beat per request:
//   status, found_ip, found, conflict.
//   Each request walks every slot of the table through a single read port and
//   one mac/ip comparator pair, one slot per cycle. After acceptance the
//   sequencer steps through S_SCAN, S_DRAIN and S_FINISH, where the result is
//   loaded; the next request can be taken in the cycle after the load, and
//   in_stall is high for the whole walk, one request at a time.
//   The result sits in an output register; the next request can be accepted
//   while it waits. If the receiver stalls, a finished walk holds until the
//   output register is free, and the table update is committed with the load.
//   Reset clears all slot valid bits, the sequencer and the output register;
//   slot contents are not cleared and are only ever read behind a valid bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mac_ip_binding_table_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  mipb_pkg::op_t             op,
  input  logic [mipb_pkg::MAC_W-1:0] mac,
  input  logic [mipb_pkg::IP_W-1:0]  ip,
  output logic                      out_valid,
  input  logic                      out_stall,
  output mipb_pkg::status_t         status,
  output logic [mipb_pkg::IP_W-1:0]  found_ip,
  output logic                      found,
  output logic                      conflict
);

  import mipb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;

  // request held for the walk
  op_t              op_q;
  logic [MAC_W-1:0] mac_q;
  logic [IP_W-1:0]  ip_q;

  // table storage
  logic [ENTRIES-1:0] entry_valid;
  logic [MAC_W-1:0]   entry_mac [ENTRIES];
  logic [IP_W-1:0]    entry_ip  [ENTRIES];

  // read stage
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_live;
  logic             cmp_valid;
  logic [MAC_W-1:0] rd_mac;
  logic [IP_W-1:0]  rd_ip;

  // walk results
  logic             mac_hit;
  logic             pair_hit;
  logic             ip_hit;
  logic             free_hit;
  logic [IDX_W-1:0] hit_idx;
  logic [IP_W-1:0]  hit_ip;
  logic [IDX_W-1:0] free_idx;

  logic    load;
  logic    any_hit;
  logic    do_write;
  logic    do_clear;
  status_t status_next;
  logic    found_next;
  logic    conflict_next;
  logic [IP_W-1:0] found_ip_next;

  assign in_stall = (state != S_IDLE);
  assign load     = (state == S_FINISH) && !(out_valid && out_stall);
  assign any_hit  = mac_hit || ip_hit;

  always_comb begin
    status_next   = ST_OK;
    found_next    = 1'b0;
    found_ip_next = '0;
    conflict_next = 1'b0;
    do_write      = 1'b0;
    do_clear      = 1'b0;
    unique case (op_q)
      OP_ADD: begin
        if (any_hit) begin
          status_next = ST_EXISTS;
        end else if (!free_hit) begin
          status_next = ST_FULL;
        end else begin
          do_write = 1'b1;
        end
      end
      OP_DELETE: begin
        if (pair_hit) begin
          do_clear = 1'b1;
        end else begin
          status_next = ST_NOTFOUND;
        end
      end
      OP_SEARCH: begin
        if (mac_hit) begin
          found_next    = 1'b1;
          found_ip_next = hit_ip;
        end else begin
          status_next = ST_NOTFOUND;
        end
      end
      OP_CONFLICT: begin
        conflict_next = any_hit && !pair_hit;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cmp_live <= 1'b0;
      rd_idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          cmp_live <= 1'b0;
          rd_idx   <= '0;
          if (in_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_live <= 1'b1;
          if (rd_idx == IDX_W'(ENTRIES - 1)) begin
            state <= S_DRAIN;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
        S_DRAIN: begin
          // last slot is compared in this cycle
          cmp_live <= 1'b0;
          state    <= S_FINISH;
        end
        S_FINISH: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_q  <= op;
      mac_q <= mac;
      ip_q  <= ip;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (load && do_write) begin
      entry_mac[free_idx] <= mac_q;
      entry_ip[free_idx]  <= ip_q;
    end
    rd_mac <= entry_mac[rd_idx];
    rd_ip  <= entry_ip[rd_idx];
  end

  always_ff @(posedge clk) begin
    cmp_idx   <= rd_idx;
    cmp_valid <= entry_valid[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (load && do_write) begin
      entry_valid[free_idx] <= 1'b1;
    end else if (load && do_clear) begin
      entry_valid[hit_idx] <= 1'b0;
    end
  end

  // compare stage, one slot per cycle
  always_ff @(posedge clk) begin
    if (rst || (state == S_IDLE)) begin
      mac_hit  <= 1'b0;
      pair_hit <= 1'b0;
      ip_hit   <= 1'b0;
      free_hit <= 1'b0;
    end else if (cmp_live) begin
      if (cmp_valid && rd_mac == mac_q) begin
        // macs are unique, so at most one slot lands here
        mac_hit  <= 1'b1;
        hit_idx  <= cmp_idx;
        hit_ip   <= rd_ip;
        pair_hit <= (rd_ip == ip_q);
      end
      if (cmp_valid && rd_ip == ip_q) begin
        ip_hit <= 1'b1;
      end
      if (!cmp_valid && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= cmp_idx;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status   <= status_next;
      found_ip <= found_ip_next;
      found    <= found_next;
      conflict <= conflict_next;
    end
  end

`include "assert_macros.svh"

  `MIPB_ASSERT(a_accept_starts_walk, (in_valid && !in_stall) |=> (state == S_SCAN && rd_idx == '0))
  `MIPB_ASSERT(a_finish_loads, (state == S_FINISH && !(out_valid && out_stall)) |=> out_valid)
  `MIPB_ASSERT(a_found_means_ok, (out_valid && found) |-> (status == ST_OK && !conflict))
  `MIPB_ASSERT_ALWAYS(a_reset_clears_table, rst |=> (entry_valid == '0))

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MAC/IPv4 binding table: directed corner cases,
// a fill to capacity, a long output hold-off and three random phases with
// varying idle on both channels, checked beat by beat against a local model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mipb_pkg::*;

  localparam int POOL_SIZE = 96;

  typedef struct packed {
    status_t         status;
    logic [IP_W-1:0] found_ip;
    logic            found;
    logic            conflict;
  } binding_reply_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  op_t               op = OP_ADD;
  logic [MAC_W-1:0]  mac = '0;
  logic [IP_W-1:0]   ip = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  status_t           status;
  logic [IP_W-1:0]   found_ip;
  logic              found;
  logic              conflict;

  // local copy of the table
  logic              bound_valid [ENTRIES];
  logic [MAC_W-1:0]  bound_mac   [ENTRIES];
  logic [IP_W-1:0]   bound_ip    [ENTRIES];

  logic [MAC_W-1:0]  mac_pool [POOL_SIZE];
  logic [IP_W-1:0]   ip_pool  [POOL_SIZE];

  binding_reply_t    expected_replies [$];
  int                mismatch_count = 0;
  int                send_idle_pct = 35;
  int                recv_idle_pct = 48;
  logic              hold_off = 1'b0;

  mac_ip_binding_table_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .mac       (mac),
    .ip        (ip),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .found_ip  (found_ip),
    .found     (found),
    .conflict  (conflict)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  task automatic report_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // applies one request to the local table and returns the reply it gives
  function automatic binding_reply_t predict_binding(input op_t o, input logic [MAC_W-1:0] m,
                                                     input logic [IP_W-1:0] a);
    binding_reply_t r;
    int             pair_slot;
    int             mac_slot;
    int             free_slot;
    logic           any_hit;
    r = '{status: ST_OK, found_ip: '0, found: 1'b0, conflict: 1'b0};
    pair_slot = -1;
    mac_slot  = -1;
    free_slot = -1;
    any_hit   = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (bound_valid[i]) begin
        if (bound_mac[i] == m && bound_ip[i] == a && pair_slot < 0) pair_slot = i;
        if (bound_mac[i] == m && mac_slot < 0) mac_slot = i;
        if (bound_mac[i] == m || bound_ip[i] == a) any_hit = 1'b1;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    case (o)
      OP_ADD: begin
        // duplicate check wins over the fullness check
        if (any_hit) begin
          r.status = ST_EXISTS;
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          bound_valid[free_slot] = 1'b1;
          bound_mac[free_slot]   = m;
          bound_ip[free_slot]    = a;
        end
      end
      OP_DELETE: begin
        if (pair_slot < 0) r.status = ST_NOTFOUND;
        else bound_valid[pair_slot] = 1'b0;
      end
      OP_SEARCH: begin
        if (mac_slot < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.found    = 1'b1;
          r.found_ip = bound_ip[mac_slot];
        end
      end
      default: begin
        r.conflict = (pair_slot < 0) && any_hit;
      end
    endcase
    return r;
  endfunction

  function automatic int bound_count();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) n += bound_valid[i];
    return n;
  endfunction

  function automatic int pick_bound_slot();
    int idx;
    if (bound_count() == 0) return -1;
    do idx = $urandom_range(ENTRIES - 1); while (!bound_valid[idx]);
    return idx;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[MAC_W-1:0];
  endfunction

  // offers one request beat and records its reply once accepted
  task automatic send_beat(input op_t o, input logic [MAC_W-1:0] m, input logic [IP_W-1:0] a);
    binding_reply_t reply;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    mac      <= m;
    ip       <= a;
    do @(posedge clk); while (in_stall);
    reply = predict_binding(o, m, a);
    expected_replies = {expected_replies, reply};
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_replies
    binding_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        report_error($sformatf("result beat with nothing expected, status %s", status.name()));
      end else begin
        want = expected_replies.pop_front();
        if (status !== want.status)
          report_error($sformatf("status got %s expected %s", status.name(),
                                 want.status.name()));
        if (found_ip !== want.found_ip)
          report_error($sformatf("found_ip got %h expected %h", found_ip, want.found_ip));
        if (found !== want.found)
          report_error($sformatf("found got %b expected %b", found, want.found));
        if (conflict !== want.conflict)
          report_error($sformatf("conflict got %b expected %b", conflict, want.conflict));
      end
    end
  end

  task automatic hold_receiver(input int cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  task automatic test_directed();
    send_beat(OP_SEARCH,   '0, '0);
    send_beat(OP_DELETE,   '0, '0);
    send_beat(OP_CONFLICT, '0, '0);
    send_beat(OP_ADD,      '0, '0);
    send_beat(OP_ADD,      '1, '1);
    // same mac, then same ip
    send_beat(OP_ADD,      '0, 32'd5);
    send_beat(OP_ADD,      48'd1, '1);
    send_beat(OP_SEARCH,   '0, '0);
    send_beat(OP_SEARCH,   '1, 32'h1234_5678);
    send_beat(OP_CONFLICT, '1, '1);
    send_beat(OP_CONFLICT, '0, 32'd1);
    send_beat(OP_CONFLICT, 48'd7, '1);
    send_beat(OP_CONFLICT, 48'd7, 32'd7);
    send_beat(OP_DELETE,   '0, 32'd1);
    send_beat(OP_DELETE,   '0, '0);
    send_beat(OP_SEARCH,   '0, '0);
    send_beat(OP_DELETE,   '1, '1);
    send_beat(OP_ADD,      48'haaaa_aaaa_aaaa, 32'h5555_5555);
    send_beat(OP_ADD,      48'h5555_5555_5555, 32'haaaa_aaaa);
    send_beat(OP_SEARCH,   48'h5555_5555_5555, '0);
    send_beat(OP_DELETE,   48'haaaa_aaaa_aaaa, 32'h5555_5555);
  endtask

  task automatic test_table_full();
    int               slot;
    logic [MAC_W-1:0] fresh_mac;
    while (bound_count() < ENTRIES) send_beat(OP_ADD, rand_mac(), $urandom);
    send_beat(OP_ADD, rand_mac(), $urandom);
    slot = pick_bound_slot();
    send_beat(OP_ADD, bound_mac[slot], $urandom);
    send_beat(OP_DELETE, bound_mac[slot], bound_ip[slot]);
    // freed slot must be reused
    fresh_mac = rand_mac();
    send_beat(OP_ADD, fresh_mac, $urandom);
    send_beat(OP_SEARCH, fresh_mac, $urandom);
    send_beat(OP_CONFLICT, fresh_mac, $urandom);
  endtask

  task automatic test_backpressure();
    // output held while requests keep coming, so the input stalls too
    fork
      hold_receiver(400);
    join_none
    repeat (8) send_beat(OP_SEARCH, bound_mac[pick_bound_slot()], $urandom);
  endtask

  task automatic send_random_request(input int add_w, input int del_w);
    int               sel;
    int               slot;
    op_t              o;
    logic [MAC_W-1:0] m;
    logic [IP_W-1:0]  a;
    sel  = $urandom_range(99);
    slot = pick_bound_slot();
    m    = mac_pool[$urandom_range(POOL_SIZE - 1)];
    a    = ip_pool[$urandom_range(POOL_SIZE - 1)];
    if ($urandom_range(9) == 0) m = rand_mac();
    if ($urandom_range(9) == 0) a = $urandom;
    if (sel < add_w) begin
      o = OP_ADD;
    end else if (sel < add_w + del_w) begin
      o = OP_DELETE;
      if (slot >= 0 && $urandom_range(9) < 7) begin
        m = bound_mac[slot];
        a = bound_ip[slot];
      end
    end else if (sel < add_w + del_w + (100 - add_w - del_w) / 2) begin
      o = OP_SEARCH;
      if (slot >= 0 && $urandom_range(9) < 6) m = bound_mac[slot];
    end else begin
      o = OP_CONFLICT;
      if (slot >= 0) begin
        case ($urandom_range(3))
          0: begin
            m = bound_mac[slot];
            a = bound_ip[slot];
          end
          1: m = bound_mac[slot];
          2: a = bound_ip[slot];
          default: ;
        endcase
      end
    end
    send_beat(o, m, a);
  endtask

  task automatic test_random(input int count, input int add_w, input int del_w);
    repeat (count) send_random_request(add_w, del_w);
  endtask

  initial begin
    // small pools so that duplicates and conflicts turn up often
    for (int i = 0; i < POOL_SIZE; i++) begin
      mac_pool[i] = rand_mac();
      ip_pool[i]  = $urandom;
    end
    mac_pool[0] = '0;
    mac_pool[1] = '1;
    ip_pool[0]  = '0;
    ip_pool[1]  = '1;
    for (int i = 0; i < ENTRIES; i++) bound_valid[i] = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    wait_for_replies();
    test_table_full();
    wait_for_replies();
    test_backpressure();
    wait_for_replies();
    test_random(580, 30, 30);
    wait_for_replies();
    send_idle_pct = 48;
    recv_idle_pct = 35;
    test_random(580, 45, 20);
    wait_for_replies();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(580, 25, 40);
    wait_for_replies();
    repeat (150) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: mac_ip_binding_table_core.f
+incdir+rtl/core
rtl/core/mipb_pkg.sv
rtl/core/mac_ip_binding_table_core.sv
dv/tb.sv
